### src/tehs_pkg.sv
package tehs_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int TAG_BITS_DEF    = 16;
    localparam logic [30:0] LATE_LIMIT_RST = 31'd10000000;

    localparam logic [1:0] FUNC_SCHED   = 2'd0;
    localparam logic [1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [1:0] FUNC_REQUEUE = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_DUE     = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_REBASE_RD,
        S_REBASE_WR,
        S_INS_START,
        S_INS_RD,
        S_INS_CMP,
        S_INS_WR,
        S_ACK,
        S_RUN_RD,
        S_RUN_CHK,
        S_DUE,
        S_POP_LAST,
        S_POP_RDL,
        S_POP_RDR,
        S_POP_CMP,
        S_POP_FIN,
        S_SUMMARY
    } t_state;

    // datapath commands
    typedef enum logic [4:0] {
        C_NONE,
        C_LOAD,
        C_REB_INIT,
        C_REB_RD,
        C_REB_WR,
        C_ADVANCE,
        C_INS_INIT,
        C_INS_RD,
        C_INS_CMP,
        C_INS_WR,
        C_RUN_RD,
        C_POP_LAST,
        C_POP_RDL,
        C_POP_RDR,
        C_POP_CMP,
        C_POP_FIN
    } t_cmd;

    typedef struct packed {
        logic need_rebase;
        logic full;
        logic ins_more;
        logic count_zero;
        logic due;
        logic pop_more;
        logic reb_more;
        logic pop_stop;
    } t_status;

endpackage

### src/timer_event_heap_scheduler.sv
// heap timer queue: one request at a time, walked over memory reads and writes
// schedule/requeue: insert walked down the path to the new slot, then ack; ack alone when full
// a rebase before an insert or an advance reads and rewrites every pending entry
// advance: root read and due check after the rebase, each due event popped by a walk down
// the heap then output, summary the cycle after the last check; i_stall holds each result
// the next request is accepted in the idle cycle after the last result; sync reset empties
module timer_event_heap_scheduler #(
    parameter int QUEUE_DEPTH = tehs_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = tehs_pkg::TAG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_tag,
    input  logic [30:0]        i_delay,
    input  logic [30:0]        i_elapsed,
    input  logic signed [31:0] i_lag,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [15:0]        o_event_tag,
    output logic signed [31:0] o_event_lag,
    output logic [30:0]        o_next_delay,
    output logic               o_queue_empty,
    output logic               o_queue_full,
    output logic               o_last
);
    tehs_pkg::t_cmd    cmd;
    tehs_pkg::t_status status;
    logic [15:0] res_tag;
    logic [31:0] res_lag;
    logic [30:0] res_next;
    logic        res_empty;

    tehs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .o_cmd(cmd), .i_status(status), .o_valid(o_valid),
        .i_stall(i_stall), .o_kind(o_kind), .o_is_full(o_queue_full), .o_last(o_last)
    );

    tehs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_BITS(TAG_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .i_func(i_func),
        .i_tag(i_tag), .i_delay(i_delay), .i_elapsed(i_elapsed), .i_lag(i_lag),
        .o_res_tag(res_tag), .o_res_lag(res_lag), .o_res_next(res_next),
        .o_res_empty(res_empty)
    );

    always_comb begin
        o_event_tag  = (o_kind == tehs_pkg::KIND_DUE) ? res_tag : 16'd0;
        o_event_lag  = (o_kind == tehs_pkg::KIND_DUE) ? $signed(res_lag) : 32'sd0;
        o_next_delay = (o_kind == tehs_pkg::KIND_SUMMARY && !res_empty) ? res_next : 31'd0;
        o_queue_empty = res_empty;
    end
endmodule

### src/tehs_datapath.sv
module tehs_datapath #(
    parameter int QUEUE_DEPTH = tehs_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = tehs_pkg::TAG_BITS_DEF,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tehs_pkg::t_cmd     i_cmd,
    output tehs_pkg::t_status  o_status,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_tag,
    input  logic [30:0]        i_delay,
    input  logic [30:0]        i_elapsed,
    input  logic signed [31:0] i_lag,
    output logic [15:0]        o_res_tag,
    output logic [31:0]        o_res_lag,
    output logic [30:0]        o_res_next,
    output logic               o_res_empty
);
    localparam int PW = CW + 1;

    logic [31:0]       mem_time [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] mem_tag [QUEUE_DEPTH];

    logic [30:0] r_late, r_now;
    logic [CW-1:0] r_count;
    logic [31:0] r_off;          // signed insert offset, or advance amount
    logic        r_adv;          // request advances current time
    logic [TAG_BITS-1:0] r_tag;
    logic [31:0] r_t;
    logic [CW-1:0] r_idx;
    logic [PW-1:0] r_j;
    logic [CW-1:0] r_i;
    logic [2:0]  r_h;
    logic [31:0] r_rd_time, r_l_time, r_r_time, r_moved;
    logic [TAG_BITS-1:0] r_rd_tag, r_l_tag, r_r_tag, r_moved_tag;
    logic [15:0] r_res_tag;
    logic [31:0] r_res_lag;

    // address and write port, driven by command
    logic [AW-1:0] rd_addr, wr_addr;
    logic          we;
    logic [31:0]   wd_time;
    logic [TAG_BITS-1:0] wd_tag;

    logic [CW-1:0] n_new;
    assign n_new = r_count + CW'(1);

    // amount added to current time (only positive offsets rebase)
    logic [32:0] amt_sum;
    logic        amt_pos;
    assign amt_pos = (i_cmd == tehs_pkg::C_ADVANCE) ? 1'b1 : 1'b1;
    always_comb begin
        amt_sum = {2'b0, r_now} + {1'b0, r_off};
    end

    // requeue offset
    logic signed [32:0] neg_late;
    logic [31:0] lag_sel;
    always_comb begin
        neg_late = -$signed({2'b0, r_late});
        lag_sel  = ($signed({i_lag[31], i_lag}) < neg_late) ? 32'd0 : i_lag;
    end

    logic [CW-1:0] path_idx;
    assign path_idx = CW'(n_new >> r_h);

    logic [CW-1:0] pop_n;
    assign pop_n = r_count;

    logic signed [32:0] now_s;
    assign now_s = $signed({2'b0, r_now});

    // child choice in the pop walk
    logic take_right;
    logic [31:0] sel_time;
    logic [TAG_BITS-1:0] sel_tag;
    logic [PW-1:0] sel_j;
    always_comb begin
        take_right = ((r_j + PW'(1)) < PW'(r_count)) &&
                     ($signed(r_l_time) > $signed(r_r_time));
        sel_time = take_right ? r_r_time : r_l_time;
        sel_tag  = take_right ? r_r_tag : r_l_tag;
        sel_j    = take_right ? r_j + PW'(1) : r_j;
    end

    always_comb begin
        rd_addr = '0;
        wr_addr = '0;
        we = 1'b0;
        wd_time = r_t;
        wd_tag  = r_tag;
        case (i_cmd)
            tehs_pkg::C_REB_RD:  rd_addr = AW'(r_idx);
            tehs_pkg::C_REB_WR: begin
                we = 1'b1;
                wr_addr = AW'(r_idx);
                wd_time = r_rd_time - {1'b0, r_now};
                wd_tag  = r_rd_tag;
            end
            tehs_pkg::C_INS_RD:  rd_addr = AW'(path_idx - CW'(1));
            tehs_pkg::C_INS_CMP: begin
                if ($signed(r_t) <= $signed(r_rd_time)) begin
                    we = 1'b1;
                    wr_addr = AW'(path_idx - CW'(1));
                end
            end
            tehs_pkg::C_INS_WR: begin
                we = 1'b1;
                wr_addr = AW'(n_new - CW'(1));
            end
            tehs_pkg::C_RUN_RD:   rd_addr = '0;
            tehs_pkg::C_POP_LAST: rd_addr = AW'(pop_n - CW'(1));
            tehs_pkg::C_POP_RDL:  rd_addr = AW'(r_j - PW'(1));
            tehs_pkg::C_POP_RDR:  rd_addr = AW'(r_j);
            tehs_pkg::C_POP_CMP: begin
                if (!o_status.pop_stop) begin
                    we = 1'b1;
                    wr_addr = AW'(r_i - CW'(1));
                    wd_time = sel_time;
                    wd_tag  = sel_tag;
                end
            end
            tehs_pkg::C_POP_FIN: begin
                we = 1'b1;
                wr_addr = AW'(r_i - CW'(1));
                wd_time = r_moved;
                wd_tag  = r_moved_tag;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_time[wr_addr] <= wd_time;
            mem_tag[wr_addr]  <= wd_tag;
        end
        r_rd_time <= mem_time[rd_addr];
        r_rd_tag  <= mem_tag[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_late  <= tehs_pkg::LATE_LIMIT_RST;
            r_now   <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) r_late <= i_cfg_data;
            case (i_cmd)
                tehs_pkg::C_LOAD: begin
                    r_tag <= TAG_BITS'(i_tag);
                    r_idx <= '0;
                    r_adv <= (i_func == tehs_pkg::FUNC_ADVANCE);
                    case (i_func)
                        tehs_pkg::FUNC_SCHED:   r_off <= {1'b0, i_delay};
                        tehs_pkg::FUNC_REQUEUE: r_off <= lag_sel + {1'b0, i_delay};
                        default:                r_off <= {1'b0, i_elapsed};
                    endcase
                end
                tehs_pkg::C_REB_INIT: r_idx <= '0;
                tehs_pkg::C_REB_WR:   r_idx <= r_idx + CW'(1);
                tehs_pkg::C_ADVANCE: begin
                    // an insert only rebases, an advance also moves the clock
                    if (r_adv) begin
                        if (o_status.need_rebase) r_now <= r_off[30:0];
                        else r_now <= r_now + r_off[30:0];
                    end else if (o_status.need_rebase) begin
                        r_now <= '0;
                    end
                end
                tehs_pkg::C_INS_INIT: begin
                    r_t <= r_off + {1'b0, r_now};
                    r_h <= 3'($clog2(32'(n_new) + 1) - 1);
                end
                tehs_pkg::C_INS_CMP: begin
                    if ($signed(r_t) <= $signed(r_rd_time)) begin
                        r_t   <= r_rd_time;
                        r_tag <= r_rd_tag;
                    end
                    r_h <= r_h - 3'd1;
                end
                tehs_pkg::C_INS_WR: r_count <= n_new;
                tehs_pkg::C_RUN_RD: ;
                tehs_pkg::C_POP_LAST: begin
                    r_res_tag <= 16'(r_rd_tag);
                    r_res_lag <= r_rd_time - {1'b0, r_now};
                    r_i <= CW'(1);
                    r_j <= PW'(2);
                end
                tehs_pkg::C_POP_RDL: begin
                    if (r_j == PW'(2)) begin
                        r_moved     <= r_rd_time;
                        r_moved_tag <= r_rd_tag;
                    end
                end
                tehs_pkg::C_POP_RDR: begin
                    r_l_time <= r_rd_time;
                    r_l_tag  <= r_rd_tag;
                end
                tehs_pkg::C_POP_CMP: begin
                    if (!o_status.pop_stop) begin
                        r_i <= CW'(sel_j);
                        r_j <= sel_j << 1;
                    end
                end
                tehs_pkg::C_POP_FIN: r_count <= r_count - CW'(1);
                default: ;
            endcase
        end
    end

    // right child lands in r_rd_* during C_POP_CMP
    always_comb begin
        r_r_time = r_rd_time;
        r_r_tag  = r_rd_tag;
    end

    always_comb begin
        o_status.need_rebase = amt_pos && !r_off[31] && (r_off != 32'd0) &&
                               amt_sum[31];
        o_status.full        = (r_count == CW'(QUEUE_DEPTH));
        o_status.ins_more    = (r_h != 3'd0);
        o_status.count_zero  = (r_count == '0);
        o_status.due         = ($signed({r_rd_time[31], r_rd_time}) <= now_s);
        o_status.pop_more    = (r_j < PW'(r_count));
        o_status.reb_more    = (r_idx < r_count);
        o_status.pop_stop    = ($signed(r_moved) < $signed(sel_time));
    end

    assign o_res_tag   = r_res_tag;
    assign o_res_lag   = r_res_lag;
    assign o_res_next  = 31'(r_rd_time - {1'b0, r_now});
    assign o_res_empty = (r_count == '0);
endmodule

### src/tehs_ctrl.sv
module tehs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_func,
    output tehs_pkg::t_cmd    o_cmd,
    input  tehs_pkg::t_status i_status,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_kind,
    output logic              o_is_full,
    output logic              o_last
);
    tehs_pkg::t_state r_state, n_state;
    logic [1:0] r_func;
    logic r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tehs_pkg::S_IDLE;
            r_func  <= '0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tehs_pkg::S_IDLE && i_valid) r_func <= i_func;
            if (r_state == tehs_pkg::S_INS_START) r_full <= i_status.full;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tehs_pkg::S_IDLE:
                if (i_valid && (i_func != tehs_pkg::FUNC_UNUSED))
                    n_state = tehs_pkg::S_REBASE_RD;
            tehs_pkg::S_REBASE_RD:
                if (i_status.need_rebase && i_status.reb_more)
                    n_state = tehs_pkg::S_REBASE_WR;
                else if (r_func == tehs_pkg::FUNC_ADVANCE) n_state = tehs_pkg::S_RUN_RD;
                else n_state = tehs_pkg::S_INS_START;
            tehs_pkg::S_REBASE_WR: n_state = tehs_pkg::S_REBASE_RD;
            tehs_pkg::S_INS_START:
                if (i_status.full) n_state = tehs_pkg::S_ACK;
                else n_state = tehs_pkg::S_INS_RD;
            tehs_pkg::S_INS_RD:
                if (i_status.ins_more) n_state = tehs_pkg::S_INS_CMP;
                else n_state = tehs_pkg::S_INS_WR;
            tehs_pkg::S_INS_CMP: n_state = tehs_pkg::S_INS_RD;
            tehs_pkg::S_INS_WR: n_state = tehs_pkg::S_ACK;
            tehs_pkg::S_ACK: if (!i_stall) n_state = tehs_pkg::S_IDLE;
            tehs_pkg::S_RUN_RD: n_state = tehs_pkg::S_RUN_CHK;
            tehs_pkg::S_RUN_CHK:
                if (!i_status.count_zero && i_status.due) n_state = tehs_pkg::S_POP_LAST;
                else n_state = tehs_pkg::S_SUMMARY;
            tehs_pkg::S_POP_LAST: n_state = tehs_pkg::S_POP_RDL;
            tehs_pkg::S_POP_RDL:
                if (i_status.pop_more) n_state = tehs_pkg::S_POP_RDR;
                else n_state = tehs_pkg::S_POP_FIN;
            tehs_pkg::S_POP_RDR: n_state = tehs_pkg::S_POP_CMP;
            tehs_pkg::S_POP_CMP:
                if (i_status.pop_stop) n_state = tehs_pkg::S_POP_FIN;
                else n_state = tehs_pkg::S_POP_RDL;
            tehs_pkg::S_POP_FIN: n_state = tehs_pkg::S_DUE;
            tehs_pkg::S_DUE: if (!i_stall) n_state = tehs_pkg::S_RUN_RD;
            tehs_pkg::S_SUMMARY: if (!i_stall) n_state = tehs_pkg::S_IDLE;
            default: n_state = tehs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = tehs_pkg::C_NONE;
        o_stall   = 1'b1;
        o_valid   = 1'b0;
        o_kind    = tehs_pkg::KIND_ACK;
        o_is_full = 1'b0;
        o_last    = 1'b0;
        case (r_state)
            tehs_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) o_cmd = tehs_pkg::C_LOAD;
            end
            tehs_pkg::S_REBASE_RD:
                if (i_status.need_rebase && i_status.reb_more) o_cmd = tehs_pkg::C_REB_RD;
                else o_cmd = tehs_pkg::C_ADVANCE;
            tehs_pkg::S_REBASE_WR: o_cmd = tehs_pkg::C_REB_WR;
            tehs_pkg::S_INS_START: o_cmd = tehs_pkg::C_INS_INIT;
            tehs_pkg::S_INS_RD: o_cmd = tehs_pkg::C_INS_RD;
            tehs_pkg::S_INS_CMP: o_cmd = tehs_pkg::C_INS_CMP;
            tehs_pkg::S_INS_WR: o_cmd = tehs_pkg::C_INS_WR;
            tehs_pkg::S_ACK: begin
                o_valid = 1'b1;
                o_is_full = r_full;
                o_last = 1'b1;
            end
            tehs_pkg::S_RUN_RD: o_cmd = tehs_pkg::C_RUN_RD;
            tehs_pkg::S_POP_LAST: o_cmd = tehs_pkg::C_POP_LAST;
            tehs_pkg::S_POP_RDL: o_cmd = tehs_pkg::C_POP_RDL;
            tehs_pkg::S_POP_RDR: o_cmd = tehs_pkg::C_POP_RDR;
            tehs_pkg::S_POP_CMP: o_cmd = tehs_pkg::C_POP_CMP;
            tehs_pkg::S_POP_FIN: o_cmd = tehs_pkg::C_POP_FIN;
            tehs_pkg::S_DUE: begin
                o_valid = 1'b1;
                o_kind = tehs_pkg::KIND_DUE;
            end
            tehs_pkg::S_SUMMARY: begin
                o_valid = 1'b1;
                o_kind = tehs_pkg::KIND_SUMMARY;
                o_last = 1'b1;
            end
            default: ;
        endcase
    end
endmodule
